// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define LKV_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Table size, derived widths, command codes and the request/response types.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [0:0] {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } rsp_t;

endpackage

// File: sv/lkv_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value table
// Fully associative store with parallel key match and recency ranks.
// Evaluates one request per step and updates all entries at the clock edge.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkv_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic [lkv_pkg::CAP_W-1:0]    cap_i,
  input  logic                         step_i,
  input  lkv_pkg::req_t                req_i,
  output lkv_pkg::rsp_t                rsp_o
);
  import lkv_pkg::*;

  logic signed [DATA_W-1:0] key_q   [ENTRIES];
  logic signed [DATA_W-1:0] value_q [ENTRIES];
  logic [RANK_W-1:0]        rank_q  [ENTRIES];
  logic [RANK_W-1:0]        rank_d  [ENTRIES];
  logic [ENTRIES-1:0]       valid_q, valid_d;
  logic [CNT_W-1:0]         count_q, count_d;

  logic [ENTRIES-1:0]       match;
  logic [ENTRIES-1:0]       lru;
  logic [ENTRIES-1:0]       first_free;
  logic [ENTRIES-1:0]       slot;
  logic                     hit;
  logic [RANK_W-1:0]        hit_rank;
  logic signed [DATA_W-1:0] hit_value;
  logic [RANK_W-1:0]        lru_rank;
  logic [CNT_W-1:0]         eff_cap;
  logic                     full;
  logic                     is_put;
  logic                     insert;
  logic                     evict;

  // Capacity zero acts as one, anything past the table size as the table size.
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_i) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_i);
    end
  end

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == req_i.key);
      hit_rank  = hit_rank | (rank_q[i] & {RANK_W{match[i]}});
      hit_value = hit_value | (value_q[i] & {DATA_W{match[i]}});
    end
  end

  assign hit        = |match;
  assign is_put     = (req_i.cmd == CMD_PUT);
  assign full       = (count_q >= eff_cap);
  assign insert     = is_put && !hit;
  assign evict      = insert && full;
  // Valid ranks always form 0 .. count-1, so the oldest entry holds count-1.
  assign lru_rank   = RANK_W'(count_q - 1'b1);
  assign first_free = ~valid_q & (valid_q + 1'b1);
  assign slot       = evict ? lru : first_free;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (hit) begin
      // Move the hit entry to the front; age only those ahead of it.
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end
    end else if (insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (valid_q[i]) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end
      count_d = evict ? count_q : CNT_W'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (clear_i) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (step_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !clear_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (insert && slot[i]) begin
          key_q[i]   <= req_i.key;
          value_q[i] <= req_i.value;
        end else if (is_put && match[i]) begin
          value_q[i] <= req_i.value;
        end
      end
    end
  end

  assign rsp_o.hit        = hit;
  assign rsp_o.read_value = (hit && !is_put) ? hit_value : '0;
  assign rsp_o.evicted    = evict;

  `LKV_ASSERT(a_match_unique, $onehot0(match), "key matches more than one valid entry")
  `LKV_ASSERT(a_count_tracks_valid, $countones(valid_q) == int'(count_q), "entry count out of step with valid bits")
  `LKV_ASSERT(a_evict_keeps_count, (step_i && !clear_i && evict) |=> (count_q == $past(count_q)), "eviction changed the entry count")

endmodule

// File: sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative 16-entry key-value store with least-recently-used
// replacement, valid/ready request and response channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries cmd_i (0 get, 1 put), key_i
//   and value_i. Every transaction yields exactly one response on the output
//   channel (out_valid_o/out_ready_i): hit_o, read_value_o (stored value on a
//   get hit, else 0) and evicted_o (a put pushed out the oldest entry).
//   The request register loads on acceptance; the response register loads from
//   it when the request advances. Throughput is one transaction per cycle while
//   the receiver does not stall: the lookup, rank update and table write all fit
//   between the request register and the response register.
//   When the receiver stalls, the response register holds and the request
//   register fills; in_ready_o drops only while both are occupied.
//   The configuration channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes the
//   capacity and empties the table; write it only while no transaction is in
//   flight. Reset empties the table and sets the capacity to 16; no clearing
//   pass is needed, the block accepts requests right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [lkv_pkg::DATA_W-1:0] read_value_o,
  output logic                              evicted_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_data_i
);
  import lkv_pkg::*;

  logic             in_valid_q;
  req_t             req_q;
  logic             out_valid_q;
  rsp_t             rsp_q;
  rsp_t             rsp;
  logic [CAP_W-1:0] cap_q;
  logic             advance;
  logic             in_take;
  logic             cfg_write;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: load on their handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.cmd   <= cmd_e'(cmd_i);
      req_q.key   <= key_i;
      req_q.value <= value_i;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  lkv_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_write),
    .cap_i   (cap_q),
    .step_i  (advance),
    .req_i   (req_q),
    .rsp_o   (rsp)
  );

  assign out_valid_o  = out_valid_q;
  assign hit_o        = rsp_q.hit;
  assign read_value_o = rsp_q.read_value;
  assign evicted_o    = rsp_q.evicted;

endmodule
